>>> rtl/touch_contact_tracker_defines.svh
// ----------------------------------------------------------------------------
// Touch contact tracker assertion macros
// Shared property wrappers clocked on aclk, disabled during reset.
// ----------------------------------------------------------------------------
`ifndef TOUCH_CONTACT_TRACKER_DEFINES_SVH
`define TOUCH_CONTACT_TRACKER_DEFINES_SVH

// Same-cycle implication
`define TCT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("tct check failed");

// Next-cycle implication
`define TCT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("tct check failed");

`endif

>>> rtl/tct_pkg.sv
// ----------------------------------------------------------------------------
// Touch contact tracker package
// Field widths, event codes and default sizes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tct_pkg;

    // Slot count default and per-frame contact limit
    localparam int DEF_SLOTS      = 5;
    localparam int FRAME_CONTACTS = 5;

    // Field widths and max-reports reset value
    localparam int MAXREP_W  = 5;
    localparam int MAXREP_RST = 16;
    localparam int CIDX_W    = 3;
    localparam int COORD_W   = 16;
    localparam int SLOTID_W  = 3;
    localparam int COUNT_W   = 4;
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 56;

    // Event codes
    typedef enum logic [1:0] {
        EV_PRESSED  = 2'd0,
        EV_MOVED    = 2'd1,
        EV_RELEASED = 2'd2,
        EV_DONE     = 2'd3
    } event_t;

    // Input kind codes
    localparam logic KIND_CONTACT = 1'b0;
    localparam logic KIND_EOF     = 1'b1;

endpackage

>>> rtl/touch_contact_tracker.sv
// ----------------------------------------------------------------------------
// Touch contact tracker
// Turns per-frame contact reports into pressed / moved / released events.
// ----------------------------------------------------------------------------
// A contact request yields its event in the output register in the cycle after
//   acceptance. End of frame scans one slot per cycle while the output is free,
//   ending early at the report cap, then emits frame done.
// Throughput: one contact per cycle if the output is free; the scan blocks input.
// Reset: synchronous, active low; clears slot flags, counters and max_reports
//   to 16. Stored points are not cleared.
`timescale 1ns / 1ps

`include "touch_contact_tracker_defines.svh"

module touch_contact_tracker #(
    parameter int SLOTS = tct_pkg::DEF_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // config
    input  logic                          cfg_we,
    input  logic [tct_pkg::MAXREP_W-1:0]  cfg_wdata,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // contact_tag[7:0], pos_x[23:8], pos_y[39:24], strength[55:40]
    input  logic [tct_pkg::S_TDATA_W-1:0] s_tdata,
    // kind[0]
    input  logic                          s_tuser,
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // slot_id[2:0], out_x[18:3], out_y[34:19], pressure[50:35],
    // report_count[54:51], zero pad[55]
    output logic [tct_pkg::M_TDATA_W-1:0] m_tdata,
    // event_res[1:0]
    output logic [1:0]                    m_tuser,
    output logic                          m_tlast
);
    import tct_pkg::*;

    localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int IDX_W  = $clog2(SLOTS + 1);
    localparam int CNT_W  = $clog2(FRAME_CONTACTS + SLOTS + 1);
    localparam int PT_W   = 3 * COORD_W;

    typedef enum logic {
        ST_IDLE,
        ST_SCAN
    } state_t;

    state_t               state_reg, state_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic [CIDX_W-1:0]    cidx_reg, cidx_next;
    logic [CNT_W-1:0]     reports_reg, reports_next;
    logic [SLOTS-1:0]     active_reg, active_next;
    logic [SLOTS-1:0]     seen_reg, seen_next;
    logic [MAXREP_W-1:0]  max_reg, max_next;

    logic                 m_valid_reg, m_valid_next;
    event_t               m_event_reg, m_event_next;
    logic [SLOTID_W-1:0]  m_slot_reg, m_slot_next;
    logic [PT_W-1:0]      m_point_reg, m_point_next;
    logic [COUNT_W-1:0]   m_count_reg, m_count_next;
    logic                 m_last_reg, m_last_next;

    logic [PT_W-1:0]      last_point_reg [SLOTS];

    // Request decode
    logic [7:0]           tid;
    logic [7:0]           slot_wide;
    logic [SLOT_W-1:0]    slot_sel;
    logic                 out_free;
    logic                 take;
    logic                 frame_full;
    logic                 slot_ok;
    logic                 cap_ok;
    logic                 emit_contact;
    logic [SLOT_W-1:0]    scan_slot;
    logic                 scan_end;
    logic                 scan_rel;

    assign out_free   = !m_valid_reg || m_tready;
    assign s_tready   = (state_reg == ST_IDLE) && out_free;
    assign take       = s_tvalid && s_tready;

    assign tid        = s_tdata[7:0];
    assign slot_wide  = (tid < 8'(SLOTS)) ? tid : {{(8-CIDX_W){1'b0}}, cidx_reg};
    assign slot_sel   = slot_wide[SLOT_W-1:0];
    assign frame_full = cidx_reg >= CIDX_W'(FRAME_CONTACTS);
    assign slot_ok    = slot_wide < 8'(SLOTS);

    // Shared capacity compare, used by both contacts and the release scan
    assign cap_ok     = 32'(reports_reg) < 32'(max_reg);

    assign emit_contact = take && (s_tuser == KIND_CONTACT) && !frame_full &&
                          slot_ok && cap_ok;

    // Release scan, one slot per cycle while the output is free
    assign scan_slot = idx_reg[SLOT_W-1:0];
    assign scan_end  = (idx_reg == IDX_W'(SLOTS)) || !cap_ok;
    assign scan_rel  = active_reg[scan_slot] && !seen_reg[scan_slot];

    // Sequencer next-state logic
    always_comb begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cidx_next    = cidx_reg;
        reports_next = reports_reg;
        active_next  = active_reg;
        seen_next    = seen_reg;
        max_next     = cfg_we ? cfg_wdata : max_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_event_next = m_event_reg;
        m_slot_next  = m_slot_reg;
        m_point_next = m_point_reg;
        m_count_next = m_count_reg;
        m_last_next  = m_last_reg;

        case (state_reg)
            ST_IDLE: begin
                if (take) begin
                    if (s_tuser == KIND_EOF) begin
                        state_next = ST_SCAN;
                        idx_next   = '0;
                    end else if (!frame_full) begin
                        cidx_next = cidx_reg + CIDX_W'(1);
                        if (emit_contact) begin
                            reports_next       = reports_reg + CNT_W'(1);
                            seen_next[slot_sel] = 1'b1;
                            m_valid_next = 1'b1;
                            m_event_next = active_reg[slot_sel] ? EV_MOVED : EV_PRESSED;
                            m_slot_next  = SLOTID_W'(slot_wide);
                            m_point_next = s_tdata[8 +: PT_W];
                            m_count_next = '0;
                            m_last_next  = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN: begin
                if (out_free) begin
                    if (scan_end) begin
                        // frame done, roll seen set into active set unless max_reports is zero
                        m_valid_next = 1'b1;
                        m_event_next = EV_DONE;
                        m_slot_next  = '0;
                        m_point_next = '0;
                        m_count_next = reports_reg[COUNT_W-1:0];
                        m_last_next  = 1'b1;
                        if (max_reg != '0) begin
                            active_next = seen_reg;
                        end
                        seen_next    = '0;
                        cidx_next    = '0;
                        reports_next = '0;
                        state_next   = ST_IDLE;
                    end else begin
                        idx_next = idx_reg + IDX_W'(1);
                        if (scan_rel) begin
                            reports_next = reports_reg + CNT_W'(1);
                            m_valid_next = 1'b1;
                            m_event_next = EV_RELEASED;
                            m_slot_next  = SLOTID_W'(idx_reg);
                            m_point_next = last_point_reg[scan_slot];
                            m_count_next = '0;
                            m_last_next  = 1'b0;
                        end
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            idx_reg     <= '0;
            cidx_reg    <= '0;
            reports_reg <= '0;
            active_reg  <= '0;
            seen_reg    <= '0;
            max_reg     <= MAXREP_W'(MAXREP_RST);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            idx_reg     <= idx_next;
            cidx_reg    <= cidx_next;
            reports_reg <= reports_next;
            active_reg  <= active_next;
            seen_reg    <= seen_next;
            max_reg     <= max_next;
            m_valid_reg <= m_valid_next;
        end
        m_event_reg <= m_event_next;
        m_slot_reg  <= m_slot_next;
        m_point_reg <= m_point_next;
        m_count_reg <= m_count_next;
        m_last_reg  <= m_last_next;
    end

    // Last point store, written by contacts that emit an event
    always_ff @(posedge aclk) begin
        if (emit_contact) begin
            last_point_reg[slot_sel] <= s_tdata[8 +: PT_W];
        end
    end

    // Output packing
    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_event_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_point_reg, m_slot_reg};

    // Checks
    `TCT_ASSERT_SAME(a_release_not_last,
        m_tvalid && (m_tuser == EV_RELEASED), !m_tlast)
    `TCT_ASSERT_SAME(a_done_is_last,
        m_tvalid && (m_tuser == EV_DONE), m_tlast && (m_tdata[SLOTID_W-1:0] == '0))
    `TCT_ASSERT_NEXT(a_eof_starts_scan,
        take && (s_tuser == KIND_EOF), (state_reg == ST_SCAN) && !s_tready)
    `TCT_ASSERT_NEXT(a_done_clears_frame,
        (state_reg == ST_SCAN) && out_free && scan_end,
        (seen_reg == '0) && (reports_reg == '0) && (cidx_reg == '0))

endmodule
